[hdl/chs_pkg.sv]
// Shared types, constants and helpers for the chained hash set engine.
// No dependencies; every other file refers to it by scoped names.
package chs_pkg;

  localparam int BUCKETS   = 2048;
  localparam int WAYS      = 4;
  localparam int KEY_CHARS = 6;
  localparam int KEY_W     = 48;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int CNT_W     = 12;
  localparam int FILL_W    = $clog2(WAYS + 1);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CHR_W     = $clog2(KEY_CHARS + 1);
  localparam int RED_STEPS = 6;               // quotient of one Horner step stays below 64
  localparam int ACC_W     = CNT_W + RED_STEPS;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1500);

  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ERASED    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_chars;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BKT_W-1:0]  bucket_index;
    logic [FILL_W-1:0] bucket_fill;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_chars;
    logic [BKT_W-1:0] bucket;
  } job_t;

  function automatic logic [5:0] char_worth(input logic [7:0] c);
    logic [5:0] w;
    w = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) w = 6'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h5A) w = 6'(c - 8'h41 + 8'd10);
    return w;
  endfunction

endpackage

[hdl/chs_front.sv]
// Front end: takes items, hashes the key one character per cycle.
// Depends on chs_pkg; hands finished jobs to chs_queue.
module chs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  chs_pkg::in_item_t         item,
  input  logic [chs_pkg::CNT_W-1:0] bucket_count,
  output logic                      idle,
  output logic                      push,
  output chs_pkg::job_t             job,
  input  logic                      q_full
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t                         state_r;
  logic [chs_pkg::CHR_W-1:0]       chr_r;
  logic [1:0]                      mode_r;
  logic [chs_pkg::KEY_W-1:0]       key_r;
  logic [chs_pkg::KEY_W-1:0]       shf_r;
  logic [chs_pkg::BKT_W-1:0]       h_r;
  logic [chs_pkg::BKT_W-1:0]       h_nxt;
  logic [chs_pkg::CNT_W-1:0]       m;
  logic [chs_pkg::ACC_W-1:0]       v;
  logic [chs_pkg::ACC_W-1:0]       dv;

  always_comb begin
    if (bucket_count == '0) m = chs_pkg::CNT_W'(1);
    else if (bucket_count > chs_pkg::CNT_W'(chs_pkg::BUCKETS)) m = chs_pkg::CNT_W'(chs_pkg::BUCKETS);
    else m = bucket_count;
  end

  // Horner from the last character: h = (11h + worth) mod m
  always_comb begin
    v = chs_pkg::ACC_W'(h_r) * chs_pkg::ACC_W'(11)
        + chs_pkg::ACC_W'(chs_pkg::char_worth(shf_r[7:0]));
    for (int k = chs_pkg::RED_STEPS - 1; k >= 0; k--) begin
      dv = chs_pkg::ACC_W'(m) << k;
      if (v >= dv) v = v - dv;
    end
    h_nxt = v[chs_pkg::BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      chr_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (take) begin
            mode_r  <= item.mode;
            key_r   <= item.key_chars;
            shf_r   <= item.key_chars;
            h_r     <= '0;
            chr_r   <= '0;
            state_r <= F_HASH;
          end
        end
        F_HASH: begin
          h_r   <= h_nxt;
          shf_r <= shf_r >> 8;
          chr_r <= chr_r + 1'b1;
          if (chr_r == chs_pkg::CHR_W'(chs_pkg::KEY_CHARS - 1)) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign idle          = (state_r == F_IDLE);
  assign push          = (state_r == F_PUSH) && !q_full;
  assign job.mode      = mode_r;
  assign job.key_chars = key_r;
  assign job.bucket    = h_r;

endmodule

[hdl/chs_queue.sv]
// Two-entry job queue between front end and back end.
// Depends on chs_pkg for the job type.
module chs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  chs_pkg::job_t push_job,
  input  logic          pop,
  output chs_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  chs_pkg::job_t slot_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= push_job;
        wp_r         <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head  = slot_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

[hdl/chs_back.sv]
// Back end: bucket memories, way compare, update and result strobe.
// Depends on chs_pkg; fed by chs_queue. Clears the valid memory after reset.
module chs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  chs_pkg::job_t      q_head,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  output chs_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {B_IDLE, B_READ, B_EXEC} bstate_t;

  logic [chs_pkg::WAYS-1:0]                        valid_mem [chs_pkg::BUCKETS];
  logic [chs_pkg::WAYS-1:0][chs_pkg::KEY_W-1:0]    key_mem   [chs_pkg::BUCKETS];

  bstate_t                                      state_r;
  chs_pkg::job_t                                job_r;
  logic [chs_pkg::WAYS-1:0]                     rd_valid_r;
  logic [chs_pkg::WAYS-1:0][chs_pkg::KEY_W-1:0] rd_keys_r;
  logic                                         clr_r;
  logic [chs_pkg::BKT_W-1:0]                    clr_cnt_r;
  logic                                         out_valid_r;
  chs_pkg::out_item_t                           out_r;

  logic                         hit;
  logic [chs_pkg::WAY_W-1:0]    hit_way;
  logic                         free;
  logic [chs_pkg::WAY_W-1:0]    free_way;
  logic [chs_pkg::WAYS-1:0]     new_valid;
  logic [2:0]                   status;
  logic                         do_ins;
  logic [chs_pkg::FILL_W-1:0]   fill;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < chs_pkg::WAYS; w++) begin
      if (rd_valid_r[w]) begin
        if (!hit && rd_keys_r[w] == job_r.key_chars) begin
          hit     = 1'b1;
          hit_way = chs_pkg::WAY_W'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = chs_pkg::WAY_W'(w);
      end
    end
    new_valid = rd_valid_r;
    do_ins    = 1'b0;
    case (job_r.mode)
      chs_pkg::MODE_INSERT: begin
        if (hit) status = chs_pkg::ST_DUPLICATE;
        else if (!free) status = chs_pkg::ST_FULL;
        else begin
          status              = chs_pkg::ST_INSERTED;
          do_ins              = 1'b1;
          new_valid[free_way] = 1'b1;
        end
      end
      chs_pkg::MODE_ERASE: begin
        if (hit) begin
          status             = chs_pkg::ST_ERASED;
          new_valid[hit_way] = 1'b0;
        end else status = chs_pkg::ST_NOT_FOUND;
      end
      default: status = hit ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
    endcase
    fill = '0;
    for (int w = 0; w < chs_pkg::WAYS; w++) fill = fill + chs_pkg::FILL_W'(new_valid[w]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (clr_r) begin
        valid_mem[clr_cnt_r] <= '0;
        clr_cnt_r            <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == chs_pkg::BKT_W'(chs_pkg::BUCKETS - 1)) clr_r <= 1'b0;
      end else begin
        unique case (state_r)
          B_IDLE: begin
            if (!q_empty) begin
              job_r   <= q_head;
              state_r <= B_READ;
            end
          end
          B_READ: begin
            rd_valid_r <= valid_mem[job_r.bucket];
            rd_keys_r  <= key_mem[job_r.bucket];
            state_r    <= B_EXEC;
          end
          B_EXEC: begin
            valid_mem[job_r.bucket] <= new_valid;
            if (do_ins) key_mem[job_r.bucket][free_way] <= job_r.key_chars;
            out_r.status       <= status;
            out_r.bucket_index <= job_r.bucket;
            out_r.bucket_fill  <= fill;
            out_valid_r        <= 1'b1;
            state_r            <= B_IDLE;
          end
          default: state_r <= B_IDLE;
        endcase
      end
    end
  end

  assign pop       = !clr_r && (state_r == B_IDLE) && !q_empty;
  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/chained_hash_set_engine.sv]
// Chained hash set engine: 6-character keys, bucket memory of WAYS keys each.
// Top level; instantiates chs_front, chs_queue and chs_back; uses chs_pkg.
//
// Usage:
//   Input: drive in_data (mode, key_chars) with start; the item is taken at
//   an edge where start is high and busy is low.
//   Result: out_data (status, bucket_index, bucket_fill) is shown for one
//   cycle with out_valid high. The receiver cannot stall; none is needed.
//   Config: cfg_valid/cfg_data writes bucket_count; cfg_ready is always high.
//   Write it only while no item is in flight.
// Timing:
//   The front end hashes one character per cycle (one Horner step with a
//   six-stage compare/subtract reduction) and takes a new item only after
//   pushing the previous one to the queue. The back end handles one item
//   at a time in three steps (queue pop, registered bucket read, compare
//   and write-back); a 2-entry queue sits between them.
// Reset:
//   rst_n low clears control state and loads bucket_count with 1500. After
//   reset a clearing pass zeroes the valid memory with busy held high.
module chained_hash_set_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  chs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output chs_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [chs_pkg::CNT_W-1:0] cfg_data
);

  logic [chs_pkg::CNT_W-1:0] bucket_count_r;
  logic                      f_idle;
  logic                      f_push;
  chs_pkg::job_t             f_job;
  logic                      q_full;
  logic                      q_empty;
  chs_pkg::job_t             q_head;
  logic                      b_pop;
  logic                      b_clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= chs_pkg::CNT_RESET;
    else if (cfg_valid && cfg_ready) bucket_count_r <= cfg_data;
  end

  assign cfg_ready = 1'b1;
  assign busy      = !f_idle || b_clearing;

  chs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (start && !busy),
    .item         (in_data),
    .bucket_count (bucket_count_r),
    .idle         (f_idle),
    .push         (f_push),
    .job          (f_job),
    .q_full       (q_full)
  );

  chs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_job (f_job),
    .pop      (b_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  chs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (b_pop),
    .clearing  (b_clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hdl/chs_checker.sv]
// Port-level checks for chained_hash_set_engine, bound to the top level.
// Depends on chs_pkg for the port types.
module chs_props (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input chs_pkg::out_item_t        out_data,
  input logic                      cfg_ready
);

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after item taken");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bucket_fill <= chs_pkg::FILL_W'(chs_pkg::WAYS)
                   && out_data.status <= chs_pkg::ST_FULL))
    else $error("bad result fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("strobe right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("config port not ready");

endmodule

bind chained_hash_set_engine chs_props u_chs_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
